>>> hdl/lfu_cache_with_lru_tiebreak_assert.svh
// Assertion macros used by the top level of the cache RTL.
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define LFU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every rising clock edge outside reset.
`define LFU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> hdl/lfu_pkg.sv
// Package with the types and constants of the LFU cache.
`timescale 1ns / 1ps
package lfu_pkg;
  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int OCC_W       = $clog2(NUM_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 16;
  localparam int RANK_W      = IDX_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [OCC_W-1:0] CAP_RESET = OCC_W'(NUM_ENTRIES);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } lfu_state_t;

  // Search record that travels along the row of cells.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic [DATA_W-1:0] found_data;
    logic [RANK_W-1:0] found_rank;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              vic_valid;
    logic [IDX_W-1:0]  vic_idx;
    logic [KEY_W-1:0]  vic_key;
    logic [CNT_W-1:0]  vic_cnt;
    logic [RANK_W-1:0] vic_rank;
  } lfu_rec_t;

  // Update broadcast to every cell once the search is complete.
  typedef struct packed {
    logic              en;
    logic              fill;
    logic              write_data;
    logic [IDX_W-1:0]  sel;
    logic [OCC_W-1:0]  limit;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } lfu_cmd_t;
endpackage

>>> hdl/lfu_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface lfu_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] lookup_key;
  logic [31:0] write_value;
  modport source (output valid, opcode, lookup_key, write_value, input ready);
  modport sink (input valid, opcode, lookup_key, write_value, output ready);
endinterface

interface lfu_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_value;
  logic        evicted;
  logic [31:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

>>> hdl/lfu_cache_with_lru_tiebreak.sv
// Top level of the LFU cache with LRU tie-break.
// A fully associative 16-entry key/value cache with least-frequently-used
// replacement; among entries of equal use count the least recently accessed
// one is evicted. Each request is handled in steps: the search record walks
// the row of 16 entry cells one cell per cycle, then the update is applied
// to all cells at once and the response register is loaded. One request is
// in flight at a time; the next is taken in the cycle after the response
// has been transferred. Reset clears all valid bits, so no clearing pass is
// needed.
`timescale 1ns / 1ps
`include "lfu_cache_with_lru_tiebreak_assert.svh"
module lfu_cache_with_lru_tiebreak (
  input  logic                       clk,
  input  logic                       rst_n,
  lfu_in_if.sink                     in_ch,
  lfu_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::OCC_W-1:0]  cfg_wdata
);
  import lfu_pkg::*;

  lfu_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r;
  logic [OCC_W-1:0]  cap_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  cap_eff;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] val_r;
  logic              hit_r;
  logic [DATA_W-1:0] rd_r;
  logic              ev_r;
  logic [KEY_W-1:0]  evk_r;
  lfu_rec_t          head_rec;
  lfu_rec_t          chain [NUM_ENTRIES];
  lfu_rec_t          fin;
  lfu_cmd_t          cmd;
  logic              do_insert;
  logic              do_evict;
  logic              in_take;
  logic              out_take;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;
  assign fin      = chain[NUM_ENTRIES-1];

  // Capacity register; its value is clamped into the legal range where used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end
  assign cap_eff = (cap_r == '0) ? OCC_W'(1) :
                   (cap_r > CAP_RESET) ? CAP_RESET : cap_r;

  // Fresh search record entering the first cell.
  always_comb begin
    head_rec     = '0;
    head_rec.key = key_r;
  end

  // Row of entry cells.
  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .rec_in   ((g == 0) ? head_rec : chain[(g == 0) ? 0 : g - 1]),
      .rec_out  (chain[g]),
      .cmd      (cmd)
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_take) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == IDX_W'(NUM_ENTRIES - 1)) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_OUT;
      ST_OUT:   if (out_take) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine and the update command.
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);
    do_insert    = 1'b0;
    do_evict     = 1'b0;
    cmd          = '0;
    cmd.key      = key_r;
    cmd.data     = val_r;
    if (state_r == ST_APPLY) begin
      if (fin.found) begin
        cmd.en         = 1'b1;
        cmd.sel        = fin.found_idx;
        cmd.write_data = (op_r == OP_PUT);
        cmd.limit      = {1'b0, fin.found_rank};
      end else if (op_r == OP_PUT) begin
        cmd.en   = 1'b1;
        cmd.fill = 1'b1;
        if (occ_r < cap_eff) begin
          do_insert = 1'b1;
          cmd.sel   = fin.free_idx;
          cmd.limit = OCC_W'(NUM_ENTRIES);
        end else begin
          do_evict  = 1'b1;
          cmd.sel   = fin.vic_idx;
          cmd.limit = {1'b0, fin.vic_rank};
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == ST_SCAN) ? cnt_r + IDX_W'(1) : '0;
      if (do_insert) begin
        occ_r <= occ_r + OCC_W'(1);
      end
    end
  end

  // Request and response payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_ch.opcode;
      key_r <= in_ch.lookup_key;
      val_r <= in_ch.write_value;
    end
    if (state_r == ST_APPLY) begin
      hit_r <= fin.found;
      rd_r  <= (fin.found && op_r == OP_GET) ? fin.found_data : '0;
      ev_r  <= do_evict;
      evk_r <= do_evict ? fin.vic_key : '0;
    end
  end

  assign out_ch.hit         = hit_r;
  assign out_ch.read_value  = rd_r;
  assign out_ch.evicted     = ev_r;
  assign out_ch.evicted_key = evk_r;

  `LFU_ASSERT_IMPL(a_evict_miss, out_ch.valid && out_ch.evicted, !out_ch.hit,
                   "eviction reported on a hit")
  `LFU_ASSERT_ALWAYS(a_occ_range, occ_r <= OCC_W'(NUM_ENTRIES),
                     "occupancy above entry count")
  `LFU_ASSERT_IMPL(a_evict_has_victim, do_evict, fin.vic_valid,
                   "eviction without a valid victim")
  `LFU_ASSERT_IMPL(a_insert_has_slot, do_insert, fin.free_found,
                   "insert without a free entry")
endmodule

>>> hdl/lfu_cell.sv
// One cache entry with its slice of the search and its update logic.
`timescale 1ns / 1ps
module lfu_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lfu_pkg::IDX_W-1:0]   cell_idx,
  input  lfu_pkg::lfu_rec_t           rec_in,
  output lfu_pkg::lfu_rec_t           rec_out,
  input  lfu_pkg::lfu_cmd_t           cmd
);
  import lfu_pkg::*;

  logic              valid_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] data_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RANK_W-1:0] rank_r;
  lfu_rec_t          rec_r;
  lfu_rec_t          rec_nxt;
  logic              is_sel;

  assign is_sel = cmd.en && (cmd.sel == cell_idx);

  // Fold this entry into the passing search record.
  always_comb begin
    rec_nxt = rec_in;
    if (!rec_in.found && valid_r && key_r == rec_in.key) begin
      rec_nxt.found      = 1'b1;
      rec_nxt.found_idx  = cell_idx;
      rec_nxt.found_data = data_r;
      rec_nxt.found_rank = rank_r;
    end
    if (!rec_in.free_found && !valid_r) begin
      rec_nxt.free_found = 1'b1;
      rec_nxt.free_idx   = cell_idx;
    end
    if (valid_r && (!rec_in.vic_valid || cnt_r < rec_in.vic_cnt ||
                    (cnt_r == rec_in.vic_cnt && rank_r > rec_in.vic_rank))) begin
      rec_nxt.vic_valid = 1'b1;
      rec_nxt.vic_idx   = cell_idx;
      rec_nxt.vic_key   = key_r;
      rec_nxt.vic_cnt   = cnt_r;
      rec_nxt.vic_rank  = rank_r;
    end
  end

  // The record moves on to the next cell every cycle.
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end
  assign rec_out = rec_r;

  // Valid bit is the only entry state cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (is_sel && cmd.fill) begin
      valid_r <= 1'b1;
    end
  end

  // Entry payload, use count and recency rank.
  always_ff @(posedge clk) begin
    if (is_sel) begin
      rank_r <= '0;
      if (cmd.fill) begin
        key_r  <= cmd.key;
        data_r <= cmd.data;
        cnt_r  <= CNT_W'(1);
      end else begin
        if (cmd.write_data) begin
          data_r <= cmd.data;
        end
        if (cnt_r != CNT_MAX) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end else if (cmd.en && valid_r && {1'b0, rank_r} < cmd.limit) begin
      rank_r <= rank_r + RANK_W'(1);
    end
  end
endmodule

>>> tb/lfu_cache_with_lru_tiebreak_tb.sv
// Self-checking testbench for the LFU cache with LRU tie-break, with its own prediction model.
`timescale 1ns / 1ps
module lfu_cache_with_lru_tiebreak_tb;
  import lfu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int POOL_SIZE      = 24;

  // One expected response of the cache.
  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } cache_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [OCC_W-1:0] cfg_wdata;

  lfu_in_if  in_ch ();
  lfu_out_if out_ch ();

  lfu_cache_with_lru_tiebreak dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the cache contents used to work out each response.
  logic             ent_valid [NUM_ENTRIES];
  logic [KEY_W-1:0] ent_key   [NUM_ENTRIES];
  logic [DATA_W-1:0] ent_data [NUM_ENTRIES];
  logic [CNT_W-1:0] ent_count [NUM_ENTRIES];
  int               ent_rank  [NUM_ENTRIES];
  int               occupancy;
  logic [OCC_W-1:0] capacity_reg;

  cache_rsp_t pending_rsp[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int mismatches;
  int rsp_seen;
  int evictions_seen;
  int hits_seen;
  int items_sent;
  int quiet_cycles;

  // Clock generation.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Move entry s to the front of the recency order; younger entries below
  // the limit age by one step.
  function automatic void promote(int s, int limit);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (i != s && ent_valid[i] && ent_rank[i] < limit) begin
        ent_rank[i]++;
      end
    end
    ent_rank[s] = 0;
  endfunction

  // Apply one request to the shadow cache and return the response it gives.
  function automatic cache_rsp_t cache_access(logic op, logic [KEY_W-1:0] key,
                                              logic [DATA_W-1:0] val);
    cache_rsp_t rsp;
    int cap;
    int found;
    int slot;
    rsp = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > NUM_ENTRIES) ? NUM_ENTRIES
                                                                  : int'(capacity_reg);
    found = -1;
    slot = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (found < 0 && ent_valid[i] && ent_key[i] == key) begin
        found = i;
      end
    end
    // Hit: return or overwrite the data, count the use and refresh recency.
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (op == OP_GET) begin
        rsp.read_value = ent_data[found];
      end else begin
        ent_data[found] = val;
      end
      if (ent_count[found] != CNT_MAX) begin
        ent_count[found]++;
      end
      promote(found, ent_rank[found]);
      return rsp;
    end
    if (op == OP_GET) begin
      return rsp;
    end
    // Insert into a free slot while below capacity.
    if (occupancy < cap) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (slot < 0 && !ent_valid[i]) begin
          slot = i;
        end
      end
      promote(slot, 32'hFFFF);
      ent_valid[slot] = 1'b1;
      occupancy++;
    end else begin
      // Evict the least used entry, the oldest one among equals.
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (ent_valid[i] && (slot < 0 || ent_count[i] < ent_count[slot] ||
            (ent_count[i] == ent_count[slot] && ent_rank[i] > ent_rank[slot]))) begin
          slot = i;
        end
      end
      rsp.evicted = 1'b1;
      rsp.evicted_key = ent_key[slot];
      promote(slot, ent_rank[slot]);
    end
    ent_key[slot] = key;
    ent_data[slot] = val;
    ent_count[slot] = CNT_W'(1);
    return rsp;
  endfunction

  // Offer one request and wait for its transfer, then record the expectation.
  task automatic send_req(logic op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.lookup_key  <= key;
    in_ch.write_value <= val;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    pending_rsp.push_back(cache_access(op, key, val));
    items_sent++;
  endtask

  // Wait until every expected response has been transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register while the cache is idle.
  task automatic write_capacity(logic [OCC_W-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = cap;
  endtask

  // Response side: random ready, long hold-offs on request, and checking.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rsp_seen++;
      if (out_ch.evicted) begin
        evictions_seen++;
      end
      if (out_ch.hit) begin
        hits_seen++;
      end
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: response with none expected: hit=%0b rv=%h ev=%0b ek=%h",
                   out_ch.hit, out_ch.read_value, out_ch.evicted, out_ch.evicted_key);
        end
      end else begin
        cache_rsp_t exp_rsp;
        exp_rsp = pending_rsp.pop_front();
        if (out_ch.hit !== exp_rsp.hit || out_ch.read_value !== exp_rsp.read_value ||
            out_ch.evicted !== exp_rsp.evicted ||
            out_ch.evicted_key !== exp_rsp.evicted_key) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: response %0d expected hit=%0b rv=%h ev=%0b ek=%h", rsp_seen,
                     exp_rsp.hit, exp_rsp.read_value, exp_rsp.evicted,
                     exp_rsp.evicted_key);
            $display("       actual   hit=%0b rv=%h ev=%0b ek=%h", out_ch.hit,
                     out_ch.read_value, out_ch.evicted, out_ch.evicted_key);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Key and data extremes, all-ones data, misses and updates.
  task automatic test_basic();
    send_req(OP_GET, 32'h0, 32'h0);
    send_req(OP_PUT, 32'h0, 32'hFFFF_FFFF);
    send_req(OP_PUT, 32'hFFFF_FFFF, 32'h0);
    send_req(OP_GET, 32'h0, 32'h1234_5678);
    send_req(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_PUT, 32'h0, 32'hA5A5_5A5A);
    send_req(OP_GET, 32'h0, 32'h0);
    send_req(OP_GET, 32'h8000_0001, 32'h0);
  endtask

  // Fill the cache, raise some counts, then force evictions with ties.
  task automatic test_fill_evict();
    for (int i = 1; i <= NUM_ENTRIES; i++) begin
      send_req(OP_PUT, 32'h100 + i, i);
    end
    send_req(OP_GET, 32'h101, 32'h0);
    send_req(OP_GET, 32'h103, 32'h0);
    send_req(OP_PUT, 32'h200, 32'h200);
    send_req(OP_PUT, 32'h201, 32'h201);
    send_req(OP_PUT, 32'h202, 32'h202);
  endtask

  // Capacity extremes, out-of-range values and lowering below occupancy.
  task automatic test_capacity();
    write_capacity(5'd4);
    send_req(OP_PUT, 32'h300, 32'h1);
    send_req(OP_PUT, 32'h301, 32'h2);
    write_capacity(5'd1);
    send_req(OP_PUT, 32'h302, 32'h3);
    send_req(OP_GET, 32'h302, 32'h0);
    write_capacity(5'd0);
    send_req(OP_PUT, 32'h303, 32'h4);
    write_capacity(5'd31);
    send_req(OP_PUT, 32'h304, 32'h5);
    write_capacity(5'd16);
    send_req(OP_PUT, 32'h305, 32'h6);
  endtask

  // Raise one key's use count well above the rest, then check it survives
  // the evictions that follow.
  task automatic test_count_priority();
    write_capacity(5'd2);
    send_req(OP_PUT, 32'hC0DE_0000, 32'h77);
    for (int i = 0; i < 40; i++) begin
      send_req(OP_GET, 32'hC0DE_0000, 32'h0);
    end
    send_req(OP_PUT, 32'hC0DE_0001, 32'h1);
    send_req(OP_PUT, 32'hC0DE_0002, 32'h2);
    send_req(OP_GET, 32'hC0DE_0000, 32'h0);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    drain();
    @(negedge clk);
    hold_left <= HOLD_CYCLES;
    @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      send_req(1'($urandom_range(1)), key_pool[$urandom_range(POOL_SIZE - 1)], $urandom());
    end
  endtask

  // Random traffic over a small key pool, with the odd fully random key.
  task automatic test_random(int n_items, logic [OCC_W-1:0] cap);
    logic [KEY_W-1:0] key;
    write_capacity(cap);
    for (int i = 0; i < n_items; i++) begin
      key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(POOL_SIZE - 1)];
      send_req(1'($urandom_range(1)), key, $urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_GET;
    in_ch.lookup_key = '0;
    in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    rsp_seen = 0;
    evictions_seen = 0;
    hits_seen = 0;
    items_sent = 0;
    quiet_cycles = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i] = '0;
      ent_data[i] = '0;
      ent_count[i] = '0;
      ent_rank[i] = 0;
    end
    occupancy = 0;
    capacity_reg = CAP_RESET;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom();
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic();
    test_fill_evict();
    test_capacity();
    test_count_priority();

    send_idle_pct = 10;
    recv_idle_pct = 88;
    test_random(160, 5'd16);
    test_random(160, 5'd1);
    send_idle_pct = 88;
    recv_idle_pct = 10;
    test_random(160, 5'd8);
    test_random(160, 5'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(160, 5'd16);
    test_random(100, 5'd12);
    drain();

    $display("Covered %0d requests (%0d hits, %0d evictions, %0d responses checked),",
             items_sent, hits_seen, evictions_seen, rsp_seen);
    $display("capacities 0 to 31, use count ordering, and stalls on both channels.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_if.sv
hdl/lfu_cell.sv
hdl/lfu_cache_with_lru_tiebreak.sv
tb/lfu_cache_with_lru_tiebreak_tb.sv
